[rtl/core/rrpd_pkg.sv]
// rrpd_pkg: word types, run descriptor and constants for the rgba run-length decoder
// no dependencies
package rrpd_pkg;

    localparam logic [7:0]  CTRL_SKIP     = 8'h00;
    localparam logic [7:0]  CTRL_LITERAL  = 8'hFF;
    localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
    localparam logic [23:0] FRAME_RESET   = 24'd1048576;
    localparam logic [8:0]  DIV3_RECIP    = 9'd171;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] pixel_byte0;
        logic [7:0] pixel_byte1;
        logic [7:0] pixel_byte2;
        logic [7:0] pixel_alpha;
        logic [6:0] repeat_count;
        logic       alpha_mismatch;
        logic       overflow;
        logic       truncated;
        logic       stream_end;
    } t_out_word;

    typedef struct packed {
        logic       run_valid;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] alpha;
        logic [6:0] len;
        logic       mism;
        logic       last;
        logic       trunc;
    } t_run;

    // floor(d / 3) for an 8-bit value via reciprocal multiply
    function automatic logic [6:0] div3(input logic [7:0] d);
        logic [16:0] prod;
        prod = {9'd0, d} * {8'd0, DIV3_RECIP};
        return prod[15:9];
    endfunction

endpackage

[rtl/core/rrpd_token_fsm.sv]
// rrpd_token_fsm: token parser holding phase and partial pixel bytes
// depends on rrpd_pkg
module rrpd_token_fsm import rrpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_word i_word,
    output t_run     o_run
);

    typedef enum logic [2:0] {
        PH_CONTROL,
        PH_SKIP_COUNT,
        PH_LIT_COUNT,
        PH_LIT_PIXEL,
        PH_MIXED_PIXEL
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [6:0] r_lit_left, n_lit_left;
    logic [2:0] r_bip, n_bip;
    logic [7:0] r_color0, n_color0;
    logic [7:0] r_color1, n_color1;
    logic [7:0] r_control, n_control;
    logic       r_mism, n_mism;
    logic [7:0] d;
    logic [6:0] d3;

    assign d  = i_word.data_byte;
    assign d3 = div3(d);

    always_comb begin
        n_phase    = r_phase;
        n_lit_left = r_lit_left;
        n_bip      = r_bip;
        n_color0   = r_color0;
        n_color1   = r_color1;
        n_control  = r_control;
        n_mism     = r_mism;
        o_run      = '0;
        case (r_phase)
            PH_CONTROL: begin
                if (d == CTRL_SKIP) begin
                    n_phase = PH_SKIP_COUNT;
                end else if (d == CTRL_LITERAL) begin
                    n_phase = PH_LIT_COUNT;
                end else begin
                    n_control = d;
                    n_mism    = 1'b0;
                    n_bip     = 3'd0;
                    n_phase   = PH_MIXED_PIXEL;
                end
            end
            PH_SKIP_COUNT: begin
                n_phase = PH_CONTROL;
                if (d3 != 7'd0) begin
                    o_run.run_valid = 1'b1;
                    o_run.len       = d3;
                end
            end
            PH_LIT_COUNT: begin
                n_lit_left = d3;
                n_bip      = 3'd0;
                n_phase    = (d3 != 7'd0) ? PH_LIT_PIXEL : PH_CONTROL;
            end
            PH_LIT_PIXEL: begin
                if (r_bip == 3'd0) begin
                    n_color0 = d;
                    n_bip    = 3'd1;
                end else if (r_bip == 3'd1) begin
                    n_color1 = d;
                    n_bip    = 3'd2;
                end else begin
                    o_run.run_valid = 1'b1;
                    o_run.b0        = r_color0;
                    o_run.b1        = r_color1;
                    o_run.b2        = d;
                    o_run.alpha     = ALPHA_OPAQUE;
                    o_run.len       = 7'd1;
                    n_bip           = 3'd0;
                    n_lit_left      = r_lit_left - 7'd1;
                    if (n_lit_left == 7'd0) begin
                        n_phase = PH_CONTROL;
                    end
                end
            end
            default: begin
                case (r_bip)
                    3'd0: begin
                        n_color0 = d;
                        n_bip    = 3'd1;
                    end
                    3'd1, 3'd3: begin
                        if (d != r_control) begin
                            n_mism = 1'b1;
                        end
                        n_bip = r_bip + 3'd1;
                    end
                    3'd2: begin
                        n_color1 = d;
                        n_bip    = 3'd3;
                    end
                    default: begin
                        o_run.run_valid = 1'b1;
                        o_run.b0        = r_color0;
                        o_run.b1        = r_color1;
                        o_run.b2        = d;
                        o_run.alpha     = r_control;
                        o_run.len       = 7'd1;
                        o_run.mism      = r_mism;
                        n_bip           = 3'd0;
                        n_mism          = 1'b0;
                        n_phase         = PH_CONTROL;
                    end
                endcase
            end
        endcase
        o_run.last  = i_word.last_byte;
        o_run.trunc = (n_phase != PH_CONTROL);
        if (i_word.last_byte) begin
            n_phase    = PH_CONTROL;
            n_lit_left = 7'd0;
            n_bip      = 3'd0;
            n_color0   = 8'd0;
            n_color1   = 8'd0;
            n_control  = 8'd0;
            n_mism     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CONTROL;
            r_lit_left <= 7'd0;
            r_bip      <= 3'd0;
            r_color0   <= 8'd0;
            r_color1   <= 8'd0;
            r_control  <= 8'd0;
            r_mism     <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_lit_left <= n_lit_left;
            r_bip      <= n_bip;
            r_color0   <= n_color0;
            r_color1   <= n_color1;
            r_control  <= n_control;
            r_mism     <= n_mism;
        end
    end

endmodule

[rtl/core/rrpd_frame_clip.sv]
// rrpd_frame_clip: clips runs to the frame, tracks pixels written, forms result words
// depends on rrpd_pkg
module rrpd_frame_clip import rrpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [23:0] i_frame_pixels,
    input  t_run        i_run,
    output logic        o_valid,
    output t_out_word   o_word
);

    logic [24:0] r_written, n_written;
    logic [24:0] frame_ext;
    logic [24:0] room;
    logic [6:0]  kept;
    logic        over;

    assign frame_ext = {1'b0, i_frame_pixels};

    always_comb begin
        room = (r_written < frame_ext) ? (frame_ext - r_written) : 25'd0;
        if ({18'd0, i_run.len} < room) begin
            kept = i_run.len;
            over = 1'b0;
        end else begin
            kept = room[6:0];
            over = ({18'd0, i_run.len} > room);
        end
        o_valid = i_run.run_valid || i_run.last;
        o_word  = '0;
        n_written = r_written;
        if (i_run.run_valid) begin
            o_word.pixel_byte0    = i_run.b0;
            o_word.pixel_byte1    = i_run.b1;
            o_word.pixel_byte2    = i_run.b2;
            o_word.pixel_alpha    = i_run.alpha;
            o_word.repeat_count   = kept;
            o_word.alpha_mismatch = i_run.mism;
            o_word.overflow       = over;
            n_written             = r_written + {18'd0, kept};
        end else begin
            o_word.truncated = i_run.trunc && i_run.last;
        end
        o_word.stream_end = i_run.last;
        if (i_run.last) begin
            n_written = 25'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= 25'd0;
        end else if (i_fire) begin
            r_written <= n_written;
        end
    end

endmodule

[rtl/core/rle_rgba_pixel_decoder_core.sv]
// rle_rgba_pixel_decoder_core: top level, input register, token parser, frame clip, result register
// depends on rrpd_pkg, rrpd_token_fsm, rrpd_frame_clip
// path: input register, then token parser and frame clip, then result register
// throughput: one byte per cycle unless the output stalls, set by the single-pass parser
// reset: synchronous active low; clears both stages, parser state and pixel count,
// frame_pixels returns to 1048576
module rle_rgba_pixel_decoder_core import rrpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_word    r_in;
    logic        r_out_valid;
    t_out_word   r_out;
    logic [23:0] r_frame_pixels;
    logic        advance;
    logic        fire;
    t_run        run;
    logic        res_valid;
    t_out_word   res;

    assign advance     = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    rrpd_token_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_in),
        .o_run   (run)
    );

    rrpd_frame_clip u_clip (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_frame_pixels (r_frame_pixels),
        .i_run          (run),
        .o_valid        (res_valid),
        .o_word         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_frame_pixels <= FRAME_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= fire && res_valid;
            end
            if (i_cfg_valid) begin
                r_frame_pixels <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= res;
        end
    end

endmodule
